### rtl/assert_macros.svh
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property on the rising clock edge, off while reset is asserted.
`define ACDW_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form built on the macro above.
`define ACDW_ASSERT_IMP(name, ante, cons, msg) \
  `ACDW_ASSERT(name, (ante) |-> (cons), msg)

`endif

### rtl/acdw_pkg.sv
// Types and constants of the congestion window controller.
`timescale 1ns / 1ps

package acdw_pkg;

  localparam int unsigned WinW  = 16;
  localparam int unsigned SeqW  = 31;
  localparam int unsigned DupW  = 8;

  localparam logic [WinW-1:0] WinMax      = 16'hFFFF;
  localparam logic [WinW-1:0] ThreshReset = 16'd128;
  localparam logic [DupW-1:0] DupMax      = 8'd255;
  localparam logic [DupW-1:0] DupTrigger  = 8'd3;
  localparam logic [WinW-1:0] FastRecAdd  = 16'd3;

  // Command codes on the input tuser bit
  localparam logic CmdAck     = 1'b0;
  localparam logic CmdTimeout = 1'b1;

  typedef enum logic [1:0] {
    PhSlowStart = 2'd0,
    PhCongAvoid = 2'd1,
    PhFastRec   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KindNew     = 2'd0,
    KindDup     = 2'd1,
    KindOld     = 2'd2,
    KindTimeout = 2'd3
  } ack_kind_e;

  // One result item
  typedef struct packed {
    logic [SeqW-1:0] retransmit_seq;
    logic            retransmit;
    ack_kind_e       ack_kind;
    phase_e          phase;
    logic [WinW-1:0] threshold;
    logic [WinW-1:0] window;
  } result_t;

  // Saturating window increment
  function automatic logic [WinW-1:0] win_inc(input logic [WinW-1:0] w);
    win_inc = (w == WinMax) ? WinMax : w + 16'd1;
  endfunction

endpackage

### rtl/acdw_ctrl.sv
// Window state registers and the per-event update logic.
`timescale 1ns / 1ps

module acdw_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic                       cmd_i,
  input  logic [acdw_pkg::SeqW-1:0]  ack_i,
  input  logic                       cfg_we_i,
  input  logic [acdw_pkg::WinW-1:0]  cfg_data_i,
  output acdw_pkg::result_t          res_o
);

  logic [acdw_pkg::WinW-1:0] cwnd_q, cwnd_d;
  logic [acdw_pkg::WinW-1:0] ssth_q, ssth_d;
  acdw_pkg::phase_e          phase_q, phase_d;
  logic [acdw_pkg::DupW-1:0] dup_q, dup_d;
  logic [acdw_pkg::SeqW-1:0] last_q, last_d;
  logic                      any_q, any_d;

  logic                      is_dup, is_new;
  logic [acdw_pkg::DupW-1:0] dup_inc;
  logic [acdw_pkg::WinW:0]   cwnd_x2;
  logic [acdw_pkg::WinW-1:0] cwnd_half;

  assign is_dup    = any_q && (ack_i == last_q);
  assign is_new    = !any_q || (ack_i > last_q);
  assign dup_inc   = (dup_q == acdw_pkg::DupMax) ? acdw_pkg::DupMax : dup_q + 8'd1;
  assign cwnd_x2   = {cwnd_q, 1'b0};
  assign cwnd_half = {1'b0, cwnd_q[acdw_pkg::WinW-1:1]};

  // Next state for the event held in the input register
  always_comb begin
    logic [acdw_pkg::WinW-1:0] w_tmp;
    w_tmp   = '0;
    cwnd_d  = cwnd_q;
    ssth_d  = ssth_q;
    phase_d = phase_q;
    dup_d   = dup_q;
    last_d  = last_q;
    any_d   = any_q;
    res_o.ack_kind       = acdw_pkg::KindOld;
    res_o.retransmit     = 1'b0;
    res_o.retransmit_seq = '0;
    priority if (cmd_i == acdw_pkg::CmdTimeout) begin
      res_o.ack_kind = acdw_pkg::KindTimeout;
      cwnd_d  = 16'd1;
      phase_d = acdw_pkg::PhSlowStart;
    end else if (is_dup) begin
      res_o.ack_kind = acdw_pkg::KindDup;
      dup_d = dup_inc;
      if (phase_q == acdw_pkg::PhFastRec) begin
        cwnd_d = acdw_pkg::win_inc(cwnd_q);
      end else if (dup_inc == acdw_pkg::DupTrigger) begin
        ssth_d  = cwnd_half;
        cwnd_d  = cwnd_half + acdw_pkg::FastRecAdd;
        phase_d = acdw_pkg::PhFastRec;
        res_o.retransmit     = 1'b1;
        res_o.retransmit_seq = ack_i;
      end
    end else if (is_new) begin
      res_o.ack_kind = acdw_pkg::KindNew;
      dup_d  = '0;
      last_d = ack_i;
      any_d  = 1'b1;
      unique case (phase_q)
        acdw_pkg::PhSlowStart: begin
          if (cwnd_x2 >= {1'b0, ssth_q}) begin
            w_tmp   = acdw_pkg::win_inc(cwnd_q);
            phase_d = acdw_pkg::PhCongAvoid;
          end else begin
            w_tmp = cwnd_x2[acdw_pkg::WinW-1:0];
          end
          if (w_tmp >= ssth_q) begin
            phase_d = acdw_pkg::PhCongAvoid;
          end
          cwnd_d = w_tmp;
        end
        acdw_pkg::PhFastRec: begin
          phase_d = acdw_pkg::PhCongAvoid;
          cwnd_d  = (ssth_q == '0) ? 16'd1 : ssth_q;
        end
        default: begin
          cwnd_d = acdw_pkg::win_inc(cwnd_q);
        end
      endcase
    end
    res_o.window    = cwnd_d;
    res_o.threshold = ssth_d;
    res_o.phase     = phase_d;
  end

  // State registers; a threshold write reloads the threshold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cwnd_q  <= 16'd1;
      ssth_q  <= acdw_pkg::ThreshReset;
      phase_q <= acdw_pkg::PhSlowStart;
      dup_q   <= '0;
      last_q  <= '0;
      any_q   <= 1'b0;
    end else if (cfg_we_i) begin
      ssth_q <= cfg_data_i;
    end else if (step_i) begin
      cwnd_q  <= cwnd_d;
      ssth_q  <= ssth_d;
      phase_q <= phase_d;
      dup_q   <= dup_d;
      last_q  <= last_d;
      any_q   <= any_d;
    end
  end

endmodule

### rtl/ack_driven_congestion_window.sv
// Reno-style congestion window controller: stream ports, input and result registers.
// Each event passes the input register and then the result register on its way to the master side.
// Throughput: one event per cycle when the master side is ready. The state update is
// one pass of logic from the input register into the window state and result register.
// Stalls: the result register holds while the master side is not ready; the
// input stalls once both registers are full.
// Reset: window 1, threshold 128, slow start, no ack seen, both stages empty.
// A threshold write reloads the current threshold at once; it waits while an
// event sits in the input register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ack_driven_congestion_window (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [30:0] ack_number, [31] zero
  input  logic [0:0]  s_axis_tuser,   // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [15:0] window, [31:16] threshold, [33:32] phase,
                                      // [34] retransmit, [65:35] retransmit_seq, rest zero
  output logic [1:0]  m_axis_tuser,   // [1:0] ack_kind
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i      // [15:0] initial_threshold
);

  logic                      in_vld_q;
  logic                      cmd_q;
  logic [acdw_pkg::SeqW-1:0] ack_q;
  logic                      out_vld_q;
  acdw_pkg::result_t         out_q;
  acdw_pkg::result_t         res;
  logic                      advance;
  logic                      cfg_we;

  // Threshold writes only while no event is held, so no state update is lost
  assign cfg_ready_o   = !in_vld_q;
  assign cfg_we        = cfg_valid_i && cfg_ready_o;
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q <= s_axis_tuser[0];
      ack_q <= s_axis_tdata[acdw_pkg::SeqW-1:0];
    end
  end

  acdw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .cmd_i      (cmd_q),
    .ack_i      (ack_q),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data_i),
    .res_o      (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.ack_kind;
  assign m_axis_tdata  = {6'd0, out_q.retransmit_seq, out_q.retransmit, out_q.phase,
                          out_q.threshold, out_q.window};

  // Checks
  `ACDW_ASSERT_IMP(a_rtx_in_fast_rec, out_vld_q && out_q.retransmit,
    out_q.phase == acdw_pkg::PhFastRec && out_q.ack_kind == acdw_pkg::KindDup,
    "retransmit outside a duplicate entering fast recovery")
  `ACDW_ASSERT_IMP(a_window_nonzero, out_vld_q, out_q.window != '0,
    "window is zero")
  `ACDW_ASSERT_IMP(a_timeout_resets, out_vld_q && out_q.ack_kind == acdw_pkg::KindTimeout,
    out_q.window == 16'd1 && out_q.phase == acdw_pkg::PhSlowStart,
    "timeout result not back in slow start with window one")
  `ACDW_ASSERT_IMP(a_stage_moves, in_vld_q && !out_vld_q, ##1 out_vld_q,
    "held event did not reach the empty result register")

endmodule

### bench/ack_driven_congestion_window_tb.sv
// Self-checking bench for the Reno-style congestion window controller.
`timescale 1ns / 1ps

module ack_driven_congestion_window_tb;

  localparam int unsigned LongHold   = 300;
  localparam int unsigned DrainPause = 4;
  localparam logic [acdw_pkg::SeqW-1:0] SeqTop = {acdw_pkg::SeqW{1'b1}};

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [30:0] ack_number, [31] zero
  logic [0:0]  s_axis_tuser;   // [0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;   // [15:0] window, [31:16] threshold, [33:32] phase,
                               // [34] retransmit, [65:35] retransmit_seq
  logic [1:0]  m_axis_tuser;   // [1:0] ack_kind
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;     // [15:0] initial_threshold

  ack_driven_congestion_window dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Window state as the bench tracks it
  logic [acdw_pkg::WinW-1:0] win_q;
  logic [acdw_pkg::WinW-1:0] thr_q;
  acdw_pkg::phase_e          ph_q;
  logic [acdw_pkg::DupW-1:0] dups_q;
  logic [acdw_pkg::SeqW-1:0] last_q;
  logic                      seen_q;

  acdw_pkg::result_t pending_results[$];
  int unsigned errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_retransmits = 0;
  int unsigned n_settings = 0;
  int unsigned kind_count[4] = '{0, 0, 0, 0};
  int unsigned dup_burst_left = 0;
  bit          tx_gaps_on = 1'b1;
  bit          rx_gaps_on = 1'b1;
  bit          hold_req = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      return $urandom_range(1, 2);
    end else if (roll < 97) begin
      return $urandom_range(3, 8);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [acdw_pkg::WinW-1:0] grow_window(
    input logic [acdw_pkg::WinW-1:0] w
  );
    logic [acdw_pkg::WinW:0] sum;
    sum = {1'b0, w} + 1'b1;
    return sum[acdw_pkg::WinW] ? acdw_pkg::WinMax : sum[acdw_pkg::WinW-1:0];
  endfunction

  // Apply one event to the tracked state and build the result it yields
  function automatic acdw_pkg::result_t advance_window(
    input logic cmd, input logic [acdw_pkg::SeqW-1:0] ack
  );
    acdw_pkg::result_t       r;
    logic [acdw_pkg::WinW:0] doubled;
    r = '0;
    doubled = {win_q, 1'b0};
    if (cmd == acdw_pkg::CmdTimeout) begin
      r.ack_kind = acdw_pkg::KindTimeout;
      win_q = 16'd1;
      ph_q = acdw_pkg::PhSlowStart;
    end else if (seen_q && ack == last_q) begin
      r.ack_kind = acdw_pkg::KindDup;
      if (dups_q != acdw_pkg::DupMax) dups_q = dups_q + 1'b1;
      if (ph_q == acdw_pkg::PhFastRec) begin
        win_q = grow_window(win_q);
      end else if (dups_q == acdw_pkg::DupTrigger) begin
        // third duplicate: halve into threshold, enter fast recovery
        thr_q = win_q >> 1;
        win_q = thr_q + acdw_pkg::FastRecAdd;
        ph_q = acdw_pkg::PhFastRec;
        r.retransmit = 1'b1;
        r.retransmit_seq = ack;
      end
    end else if (!seen_q || ack > last_q) begin
      r.ack_kind = acdw_pkg::KindNew;
      dups_q = '0;
      last_q = ack;
      seen_q = 1'b1;
      case (ph_q)
        acdw_pkg::PhSlowStart: begin
          if (doubled >= {1'b0, thr_q}) begin
            ph_q = acdw_pkg::PhCongAvoid;
            win_q = grow_window(win_q);
          end else begin
            win_q = doubled[acdw_pkg::WinW-1:0];
          end
          if (win_q >= thr_q) ph_q = acdw_pkg::PhCongAvoid;
        end
        acdw_pkg::PhFastRec: begin
          ph_q = acdw_pkg::PhCongAvoid;
          win_q = (thr_q == '0) ? 16'd1 : thr_q;
        end
        default: begin
          win_q = grow_window(win_q);
        end
      endcase
    end else begin
      r.ack_kind = acdw_pkg::KindOld;
    end
    r.window = win_q;
    r.threshold = thr_q;
    r.phase = ph_q;
    return r;
  endfunction

  // Offer one event, wait for its transfer, then log the expected result
  task automatic send_event(input logic cmd, input logic [acdw_pkg::SeqW-1:0] ack);
    int unsigned       gap;
    acdw_pkg::result_t r;
    gap = (tx_gaps_on && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, ack};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    r = advance_window(cmd, ack);
    pending_results.insert(pending_results.size(), r);
    n_sent++;
    kind_count[r.ack_kind]++;
    if (r.retransmit) n_retransmits++;
  endtask

  // Stop offering and let every outstanding result come out
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainPause) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [acdw_pkg::WinW-1:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    thr_q = value;
    n_settings++;
  endtask

  // Mostly orderly ack streams with duplicate bursts; some timeouts and noise
  task automatic random_event();
    int unsigned               roll;
    logic [acdw_pkg::SeqW:0]   next_ack;
    roll = $urandom_range(0, 99);
    if (dup_burst_left != 0) begin
      dup_burst_left--;
      send_event(acdw_pkg::CmdAck, last_q);
    end else if (roll < 7) begin
      send_event(acdw_pkg::CmdTimeout, acdw_pkg::SeqW'($urandom()));
    end else if (roll < 13 && seen_q && last_q != '0) begin
      send_event(acdw_pkg::CmdAck, acdw_pkg::SeqW'($urandom_range(0, last_q - 1'b1)));
    end else if (roll < 16) begin
      send_event(acdw_pkg::CmdAck, acdw_pkg::SeqW'($urandom()));
    end else if (roll < 35 && seen_q) begin
      dup_burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 9) : 2;
      send_event(acdw_pkg::CmdAck, last_q);
    end else begin
      next_ack = {1'b0, last_q} + $urandom_range(1, 4000);
      send_event(acdw_pkg::CmdAck, next_ack[acdw_pkg::SeqW] ?
                 acdw_pkg::SeqW'($urandom()) : next_ack[acdw_pkg::SeqW-1:0]);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int unsigned gap_left;
    int unsigned held;
    gap_left = 0;
    held = 0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        held++;
        if (held == LongHold) begin
          hold_req = 1'b0;
          held = 0;
        end
      end else if (gap_left != 0) begin
        m_axis_tready <= 1'b0;
        gap_left--;
      end else if (rx_gaps_on && $urandom_range(0, 99) < 15) begin
        m_axis_tready <= 1'b0;
        gap_left = pick_gap() - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare each result transfer against the oldest expectation
  always @(posedge clk_i) begin : result_check
    acdw_pkg::result_t want;
    logic              bad;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: tdata=%0h tuser=%0d",
                                   m_axis_tdata, m_axis_tuser);
      end else begin
        want = pending_results.pop_front();
        bad = (m_axis_tdata[15:0] != want.window) ||
              (m_axis_tdata[31:16] != want.threshold) ||
              (m_axis_tdata[33:32] != want.phase) ||
              (m_axis_tuser != want.ack_kind) ||
              (m_axis_tdata[34] != want.retransmit) ||
              (m_axis_tdata[65:35] != want.retransmit_seq);
        if (bad) begin
          errors++;
          if (errors <= 10) begin
            $display("result %0d mismatch: exp win=%0d thr=%0d phase=%0d kind=%0d",
                     n_checked, want.window, want.threshold, want.phase, want.ack_kind);
            $display("  exp rtx=%0d seq=%0h", want.retransmit, want.retransmit_seq);
            $display("  got win=%0d thr=%0d phase=%0d kind=%0d rtx=%0d seq=%0h",
                     m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[33:32],
                     m_axis_tuser, m_axis_tdata[34], m_axis_tdata[65:35]);
          end
        end
        n_checked++;
      end
    end
  end

  // First ack after reset, the three ack classes and a timeout
  task automatic test_first_acks();
    send_event(acdw_pkg::CmdAck, '0);
    send_event(acdw_pkg::CmdAck, '0);
    send_event(acdw_pkg::CmdAck, 31'd10);
    send_event(acdw_pkg::CmdAck, 31'd4);
    send_event(acdw_pkg::CmdTimeout, SeqTop);
    send_event(acdw_pkg::CmdAck, 31'd10);
    send_event(acdw_pkg::CmdAck, 31'd10);
    send_event(acdw_pkg::CmdAck, 31'd11);
  endtask

  // Third duplicate, growth in fast recovery, exit on new ack
  task automatic test_fast_recovery();
    send_event(acdw_pkg::CmdAck, 31'd20);
    repeat (5) send_event(acdw_pkg::CmdAck, 31'd20);
    send_event(acdw_pkg::CmdAck, 31'd21);
  endtask

  // Zero threshold: slow start skips to avoidance, recovery exit floors at one
  task automatic test_zero_threshold();
    write_threshold('0);
    send_event(acdw_pkg::CmdTimeout, '0);
    send_event(acdw_pkg::CmdAck, 31'd30);
    send_event(acdw_pkg::CmdTimeout, 31'h2AAA_AAAA);
    repeat (3) send_event(acdw_pkg::CmdAck, 31'd30);
    send_event(acdw_pkg::CmdAck, 31'd31);
  endtask

  // Window pinned at its maximum, then doubling toward the halved threshold
  task automatic test_window_saturation();
    repeat (3) send_event(acdw_pkg::CmdAck, last_q);
    write_threshold(acdw_pkg::WinMax);
    send_event(acdw_pkg::CmdAck, last_q + 1'b1);
    send_event(acdw_pkg::CmdAck, last_q + 1'b1);
    repeat (4) send_event(acdw_pkg::CmdAck, last_q);
    send_event(acdw_pkg::CmdAck, last_q + 1'b1);
    send_event(acdw_pkg::CmdTimeout, '0);
    for (int i = 0; i < 17; i++) send_event(acdw_pkg::CmdAck, last_q + 1'b1);
  endtask

  // Duplicate counter must stick at its top, never re-arming a retransmit
  task automatic test_dup_count_saturation();
    write_threshold(acdw_pkg::ThreshReset);
    send_event(acdw_pkg::CmdAck, last_q + 1'b1);
    repeat (3) send_event(acdw_pkg::CmdAck, last_q);
    send_event(acdw_pkg::CmdTimeout, '0);
    repeat (300) send_event(acdw_pkg::CmdAck, last_q);
    send_event(acdw_pkg::CmdAck, last_q + 1'b1);
  endtask

  // Receiver holds off while events keep coming, so the input stalls
  task automatic test_backpressure();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    hold_req = 1'b1;
    repeat (80) random_event();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [acdw_pkg::WinW-1:0] levels[6];
    levels = '{16'd1, 16'd2, acdw_pkg::WinMax, 16'd0, acdw_pkg::ThreshReset, 16'd0};
    levels[3] = acdw_pkg::WinW'($urandom());
    levels[5] = acdw_pkg::WinW'($urandom_range(3, 64));
    for (int p = 0; p < 6; p++) begin
      write_threshold(levels[p]);
      tx_gaps_on = (p % 3) != 0;
      rx_gaps_on = (p % 2) == 0;
      repeat (190) random_event();
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  // Top of the sequence space, kept last since nothing can be new after it
  task automatic test_sequence_top();
    send_event(acdw_pkg::CmdAck, SeqTop);
    send_event(acdw_pkg::CmdAck, '0);
    repeat (4) send_event(acdw_pkg::CmdAck, SeqTop);
    send_event(acdw_pkg::CmdTimeout, SeqTop);
  endtask

  initial begin : test_sequence
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    win_q  = 16'd1;
    thr_q  = acdw_pkg::ThreshReset;
    ph_q   = acdw_pkg::PhSlowStart;
    dups_q = '0;
    last_q = '0;
    seen_q = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_first_acks();
    test_fast_recovery();
    test_zero_threshold();
    test_window_saturation();
    test_dup_count_saturation();
    test_backpressure();
    test_random_traffic();
    test_sequence_top();

    wait_idle();
    repeat (6) @(posedge clk_i);
    $display("Covered %0d events: %0d new, %0d duplicate, %0d old, %0d timeout.",
             n_sent, kind_count[acdw_pkg::KindNew], kind_count[acdw_pkg::KindDup],
             kind_count[acdw_pkg::KindOld], kind_count[acdw_pkg::KindTimeout]);
    $display("%0d fast retransmits, %0d threshold writes, %0d results checked, %0d errors.",
             n_retransmits, n_settings, n_checked, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
